// ----- hdl/pscl_pkg.sv -----
// Package for the per-source connection limiter.
// Status codes, action codes, register indexes, configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pscl_pkg;

	localparam int CNT_W = 12;

	typedef enum logic [2:0] {
		STAT_ADMIT   = 3'd0,
		STAT_TOTAL   = 3'd1,
		STAT_EMPTY   = 3'd2,
		STAT_ADDR    = 3'd3,
		STAT_REMOVED = 3'd4,
		STAT_ID      = 3'd5
	} status_t;

	localparam logic ACT_REGISTER   = 1'b0;
	localparam logic ACT_UNREGISTER = 1'b1;

	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_PER_ADDR = 1'b1;

	localparam logic [CNT_W-1:0] TOTAL_RESET    = 12'd2000;
	localparam logic [CNT_W-1:0] PER_ADDR_RESET = 12'd10;

	typedef struct packed {
		logic [CNT_W-1:0] total_limit;
		logic [CNT_W-1:0] per_address_limit;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hdl/pscl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pscl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/pscl_regs.sv -----
// APB-style configuration registers: total limit and per-address limit.
// Depends on pscl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pscl_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output pscl_pkg::cfg_t   cfg
);
	pscl_pkg::cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_limit <= pscl_pkg::TOTAL_RESET;
			cfg_q.per_address_limit <= pscl_pkg::PER_ADDR_RESET;
		end else if (wr) begin
			if (paddr[2] == pscl_pkg::REG_TOTAL) begin
				cfg_q.total_limit <= pwdata[pscl_pkg::CNT_W-1:0];
			end else begin
				cfg_q.per_address_limit <= pwdata[pscl_pkg::CNT_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == pscl_pkg::REG_TOTAL) begin
				prdata = {20'd0, cfg_q.total_limit};
			end else begin
				prdata = {20'd0, cfg_q.per_address_limit};
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/per_source_connection_limiter_unit.sv -----
// Top level of the per-source connection limiter: client and address tables in RAM.
// Depends on pscl_pkg, pscl_ram, pscl_regs.
//
//  port group   direction  handshake           word
//  command      in         start / busy        action, client_id, address_present,
//                                              source_address
//  result       out        done (1 cycle)      accepted, status, active_clients,
//                                              address_clients
//  config       in/out     APB psel/penable    paddr, pwdata, prdata
//
// Each word takes a full sweep of the client table,
// a full sweep of the address table (one entry a cycle, one read port each),
// then a write-back state. After reset a clearing pass over every table entry
// holds busy high. done strobes for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module per_source_connection_limiter_unit #(
	parameter int MAX_CLIENTS  = 2048,
	parameter int ADDRESS_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [31:0] client_id,
	input  wire logic        address_present,
	input  wire logic [31:0] source_address,
	output logic             done,
	output logic             accepted,
	output logic [2:0]       status,
	output logic [11:0]      active_clients,
	output logic [11:0]      address_clients,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int IW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW  = $clog2(MAX_CLIENTS + 1);
	localparam int LW  = (CW > pscl_pkg::CNT_W) ? CW : pscl_pkg::CNT_W;
	localparam int AB  = ADDRESS_BITS;
	localparam int CWD = 1 + 32 + AB;
	localparam int AWD = 1 + AB + pscl_pkg::CNT_W;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_CSCAN  = 5'b00100,
		ST_ASCAN  = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	state_t state_q;
	logic [IW:0]     cnt_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	logic            act_q, pres_q;
	logic [31:0]     id_q;
	logic [AB-1:0]   addr_q;
	logic            c_hit_q, cf_hit_q, a_hit_q, af_hit_q;
	logic [IW-1:0]   c_idx_q, cf_idx_q, a_idx_q, af_idx_q;
	logic [AB-1:0]   c_src_q;
	logic [11:0]     a_cnt_q;
	logic [CW-1:0]   active_q;
	logic            done_q, accepted_q;
	pscl_pkg::status_t status_q;
	logic [11:0]     active_clients_q, address_clients_q;

	pscl_pkg::cfg_t  cfg;
	logic [CWD-1:0]  c_rd, c_wd;
	logic [AWD-1:0]  a_rd, a_wd;
	logic            c_we, a_we;
	logic [IW-1:0]   c_wa, a_wa;
	logic [AB+31:0]  addr_ext;
	logic [AB-1:0]   addr_in, tag;
	logic            issue, scan_last, full, acc_go;
	logic            n_acc;
	pscl_pkg::status_t n_stat;
	logic [CW-1:0]   n_active;
	logic [11:0]     n_acnt, a_inc, a_dec;

	pscl_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	pscl_ram #(.WIDTH(CWD), .DEPTH(MAX_CLIENTS)) u_client_ram (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
		.raddr(cnt_q[IW-1:0]), .rdata(c_rd)
	);

	pscl_ram #(.WIDTH(AWD), .DEPTH(MAX_CLIENTS)) u_addr_ram (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
		.raddr(cnt_q[IW-1:0]), .rdata(a_rd)
	);

	assign addr_ext = {{AB{1'b0}}, source_address};
	assign addr_in  = addr_ext[AB-1:0];
	assign busy     = (state_q != ST_IDLE);
	assign acc_go   = start && !busy;
	assign issue    = ((state_q == ST_CSCAN) || (state_q == ST_ASCAN))
		&& (cnt_q < (IW+1)'(MAX_CLIENTS));
	assign scan_last = vld_s1 && (idx_s1 == IW'(MAX_CLIENTS - 1));
	assign tag = (act_q == pscl_pkg::ACT_UNREGISTER) ? (c_hit_q ? c_src_q : '0)
		: (pres_q ? addr_q : '0);
	assign full = (LW'(active_q) >= LW'(cfg.total_limit))
		|| (LW'(active_q) >= LW'(MAX_CLIENTS));
	assign a_inc = a_cnt_q + 12'd1;
	assign a_dec = a_cnt_q - 12'd1;

	always_comb begin
		c_we = 1'b0;
		a_we = 1'b0;
		c_wa = cnt_q[IW-1:0];
		a_wa = cnt_q[IW-1:0];
		c_wd = '0;
		a_wd = '0;
		n_acc = 1'b0;
		n_stat = pscl_pkg::STAT_ID;
		n_active = active_q;
		n_acnt = a_hit_q ? a_cnt_q : 12'd0;
		if (state_q == ST_CLEAR) begin
			c_we = 1'b1;
			a_we = 1'b1;
		end else if (act_q == pscl_pkg::ACT_REGISTER) begin
			if (full) begin
				n_stat = pscl_pkg::STAT_TOTAL;
			end else if (pres_q && addr_q == '0) begin
				n_stat = pscl_pkg::STAT_EMPTY;
			end else if (a_hit_q && a_cnt_q >= cfg.per_address_limit) begin
				n_stat = pscl_pkg::STAT_ADDR;
			end else if (c_hit_q) begin
				n_stat = pscl_pkg::STAT_ID;
			end else if (!cf_hit_q || (pres_q && !a_hit_q && !af_hit_q)) begin
				n_stat = pscl_pkg::STAT_TOTAL;
			end else begin
				n_acc = 1'b1;
				n_stat = pscl_pkg::STAT_ADMIT;
				n_active = active_q + CW'(1);
				c_we = (state_q == ST_UPDATE);
				c_wa = cf_idx_q;
				c_wd = {1'b1, id_q, pres_q ? addr_q : {AB{1'b0}}};
				if (pres_q) begin
					a_we = (state_q == ST_UPDATE);
					a_wa = a_hit_q ? a_idx_q : af_idx_q;
					n_acnt = a_hit_q ? a_inc : 12'd1;
					a_wd = {1'b1, addr_q, n_acnt};
				end
			end
		end else if (c_hit_q) begin
			n_acc = 1'b1;
			n_stat = pscl_pkg::STAT_REMOVED;
			n_active = (active_q != '0) ? active_q - CW'(1) : active_q;
			c_we = (state_q == ST_UPDATE);
			c_wa = c_idx_q;
			c_wd = {1'b0, id_q, c_src_q};
			if (a_hit_q) begin
				a_we = (state_q == ST_UPDATE);
				a_wa = a_idx_q;
				if (a_cnt_q <= 12'd1) begin
					n_acnt = 12'd0;
					a_wd = {1'b0, tag, 12'd0};
				end else begin
					n_acnt = a_dec;
					a_wd = {1'b1, tag, a_dec};
				end
			end
		end else begin
			n_acnt = 12'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			c_hit_q <= 1'b0;
			cf_hit_q <= 1'b0;
			a_hit_q <= 1'b0;
			af_hit_q <= 1'b0;
			active_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
			vld_s1 <= issue;
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q[IW-1:0] == IW'(MAX_CLIENTS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + (IW+1)'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CSCAN;
						cnt_q <= '0;
						c_hit_q <= 1'b0;
						cf_hit_q <= 1'b0;
						a_hit_q <= 1'b0;
						af_hit_q <= 1'b0;
					end
				end
				ST_CSCAN: begin
					if (vld_s1) begin
						if (c_rd[CWD-1] && c_rd[AB+31:AB] == id_q) c_hit_q <= 1'b1;
						if (!c_rd[CWD-1]) cf_hit_q <= 1'b1;
					end
					if (scan_last) begin
						cnt_q <= '0;
						state_q <= ST_ASCAN;
					end else if (issue) begin
						cnt_q <= cnt_q + (IW+1)'(1);
					end
				end
				ST_ASCAN: begin
					if (vld_s1) begin
						if (a_rd[AWD-1] && a_rd[AB+11:12] == tag && tag != '0) a_hit_q <= 1'b1;
						if (!a_rd[AWD-1]) af_hit_q <= 1'b1;
					end
					if (scan_last) begin
						cnt_q <= '0;
						state_q <= ST_UPDATE;
					end else if (issue) begin
						cnt_q <= cnt_q + (IW+1)'(1);
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
					active_q <= n_active;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (acc_go) begin
			act_q <= action;
			id_q <= client_id;
			pres_q <= address_present;
			addr_q <= addr_in;
		end
		if (state_q == ST_CSCAN && vld_s1) begin
			if (c_rd[CWD-1] && c_rd[AB+31:AB] == id_q) begin
				c_idx_q <= idx_s1;
				c_src_q <= c_rd[AB-1:0];
			end
			if (!c_rd[CWD-1] && !cf_hit_q) cf_idx_q <= idx_s1;
		end
		if (state_q == ST_ASCAN && vld_s1) begin
			if (a_rd[AWD-1] && a_rd[AB+11:12] == tag && tag != '0) begin
				a_idx_q <= idx_s1;
				a_cnt_q <= a_rd[11:0];
			end
			if (!a_rd[AWD-1] && !af_hit_q) af_idx_q <= idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			accepted_q <= n_acc;
			status_q <= n_stat;
			active_clients_q <= 12'(n_active);
			address_clients_q <= n_acnt;
		end
	end

	assign done = done_q;
	assign accepted = accepted_q;
	assign status = status_q;
	assign active_clients = active_clients_q;
	assign address_clients = address_clients_q;

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without write-back cycle");

	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && accepted_q) |->
		(status_q == pscl_pkg::STAT_ADMIT || status_q == pscl_pkg::STAT_REMOVED))
		else $error("accepted word with refusal status");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(active_q) <= LW'(MAX_CLIENTS))
		else $error("active count above table size");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		acc_go |=> (state_q == ST_CSCAN && cnt_q == '0))
		else $error("accepted word did not start client sweep");

endmodule
`default_nettype wire
